@@ hdl/ppdd_pkg.sv @@
// Package for the pad press deviation detector.
// Holds the window size, derived widths and the transfer payload types.
// Depends on nothing; every other file of the block imports it.
package ppdd_pkg;

   // Samples in the sliding window; must be a power of two between 2 and 64
   localparam int WINDOW_SIZE = 8;
   localparam int WIN_LOG2    = $clog2(WINDOW_SIZE);

   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = SAMPLE_W + WIN_LOG2;
   localparam int REFILL_W = WIN_LOG2;

   localparam logic [REFILL_W-1:0] REFILL_START = REFILL_W'(WINDOW_SIZE - 1);
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(64);

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic                active;
      logic                latched;
      logic [SAMPLE_W-1:0] mean;
      logic                refilling;
   } rsp_payload_type;

endpackage

@@ hdl/pad_press_deviation_detector_core.sv @@
// Top level of the pad press deviation detector.
// Depends on ppdd_pkg for widths, request kinds and payload types.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) carries either a new pad
//   sample or a clear command for the latched flag. rsp channel
//   (rsp_valid/rsp_ready/rsp_item) returns exactly one result per request:
//   active flag, latched flag, the window mean used and a refill marker.
//   csr_we/csr_wdata write the switching threshold; write only while idle.
//   A request is held in the input register and then in the result register;
//   rsp_valid rises once the result register is loaded.
//   Throughput: one request per cycle while the receiver keeps rsp_ready high;
//   the window shift and running sum update are computed combinationally
//   between the input register and the result register.
//   Reset (synchronous, active high) empties both registers, zeros the
//   window and running sum, clears both flags, loads the threshold with 64
//   and arms a refill of WINDOW_SIZE-1 samples with no detection.
//   When the receiver stalls, the result register holds; one more request
//   is then taken into the input register before req_ready drops.
module pad_press_deviation_detector_core
   import ppdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_item,
   input  logic                csr_we,
   input  logic [SAMPLE_W-1:0] csr_wdata
);

   // Input stage
   logic            in_valid_ff;
   req_payload_type in_item_ff;
   logic            in_advance;

   // Result stage
   logic            out_valid_ff;
   rsp_payload_type out_item_ff, out_item_in;

   // Detector state
   logic [SAMPLE_W-1:0] threshold_ff;
   logic [SAMPLE_W-1:0] window_ff [WINDOW_SIZE];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                pressed_ff, pressed_in;
   logic                sticky_ff, sticky_in;
   logic [REFILL_W-1:0] refill_ff, refill_in;
   logic                do_shift;

   logic [SAMPLE_W-1:0] mean;
   logic [SAMPLE_W-1:0] smp;

   // Move the input stage forward when the result register is free or draining
   assign in_advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || in_advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // Truncated mean: upper bits of the running sum
   assign mean = sum_ff[SUM_W-1:WIN_LOG2];
   assign smp  = in_item_ff.sample;

   // Decide flags, refill count and shift for the item in the input stage
   always_comb begin
      pressed_in = pressed_ff;
      sticky_in  = sticky_ff;
      refill_in  = refill_ff;
      do_shift   = 1'b0;
      out_item_in.refilling = 1'b0;
      if (in_item_ff.kind == KIND_CLEAR) begin
         sticky_in = 1'b0;
      end else if (refill_ff != '0) begin
         out_item_in.refilling = 1'b1;
         refill_in = refill_ff - 1'b1;
         do_shift  = 1'b1;
      end else begin
         do_shift = 1'b1;
         if (smp < mean && (mean - smp) > threshold_ff) begin
            pressed_in = 1'b1;
            sticky_in  = 1'b1;
            refill_in  = REFILL_START;
         end else if (smp > mean && (smp - mean) > threshold_ff) begin
            pressed_in = 1'b0;
            refill_in  = REFILL_START;
         end
      end
      out_item_in.active  = pressed_in;
      out_item_in.latched = sticky_in;
      out_item_in.mean    = mean;
   end

   // Drop the oldest sample from the sum and add the new one
   assign sum_in = sum_ff - SUM_W'(window_ff[WINDOW_SIZE-1]) + SUM_W'(smp);

   // Hold or load the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   // Hold or load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (in_advance) begin
         out_item_ff <= out_item_in;
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         threshold_ff <= csr_wdata;
      end
   end

   // Update detector state on each item that leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         pressed_ff <= 1'b0;
         sticky_ff  <= 1'b0;
         refill_ff  <= REFILL_START;
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            window_ff[i] <= '0;
         end
      end else if (in_advance) begin
         pressed_ff <= pressed_in;
         sticky_ff  <= sticky_in;
         refill_ff  <= refill_in;
         if (do_shift) begin
            sum_ff       <= sum_in;
            window_ff[0] <= smp;
            for (int i = 1; i < WINDOW_SIZE; i++) begin
               window_ff[i] <= window_ff[i-1];
            end
         end
      end
   end

endmodule

@@ hdl/ppdd_checker.sv @@
// Port-level checker for the pad press deviation detector, bound to the top level.
// Depends on ppdd_pkg for the payload types.
module ppdd_checker
   import ppdd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsp_payload_type     rsp_item
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // With no result waiting, the block must take a request
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled while result side is empty");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // A refill result never switches the active flag between back-to-back transfers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_item.refilling
      |-> rsp_item.active == $past(rsp_item.active))
      else $error("active flag changed on a refill sample");

endmodule

bind pad_press_deviation_detector_core ppdd_checker u_ppdd_checker (.*);
